@@ rtl/stx_etx_frame_receiver_top_assert.svh @@
// Assertion helpers used by the receiver back end (stxr_back).
// The including module must provide clk and rst_n.
`ifndef STX_ETX_FRAME_RECEIVER_TOP_ASSERT_SVH
`define STX_ETX_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication.
`define STXR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the following cycle.
`define STXR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/stxr_pkg.sv @@
package stxr_pkg;

  // Result status codes.
  localparam logic [2:0] STAT_STORED     = 3'd0;
  localparam logic [2:0] STAT_COMPLETE   = 3'd1;
  localparam logic [2:0] STAT_BAD_IDLE   = 3'd2;
  localparam logic [2:0] STAT_START_MID  = 3'd3;
  localparam logic [2:0] STAT_OVERFLOW   = 3'd4;
  localparam logic [2:0] STAT_BYTE_HELD  = 3'd5;
  localparam logic [2:0] STAT_RELEASED   = 3'd6;

  // Input function codes.
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_END   = 2'd1;
  localparam logic [1:0] CFG_ESC   = 2'd2;

  // Command passed from the front end to the output side.
  typedef struct packed {
    logic       dump;    // emit the whole stored frame
    logic [2:0] status;  // status of a single result
  } stxr_cmd_t;

endpackage

@@ rtl/stxr_ram.sv @@
module stxr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/stxr_queue.sv @@
module stxr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);

  // Two-entry queue.
  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  assign full  = cnt_r[1];
  assign valid = (cnt_r != 2'd0);
  assign rdata = slot_r[rd_ptr_r];

endmodule

@@ rtl/stxr_front.sv @@
module stxr_front
  import stxr_pkg::*;
#(
  parameter int FRAME_BYTES = 32,
  parameter int AW          = 5,
  parameter int CW          = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_wdata,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_func,
  input  logic [7:0]    in_rx_byte,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic          q_push,
  output stxr_cmd_t     q_cmd,
  output logic [CW-1:0] q_len,
  input  logic          q_full,
  input  logic          dump_done
);

  localparam logic [1:0] RS_IDLE = 2'd0;
  localparam logic [1:0] RS_RECV = 2'd1;
  localparam logic [1:0] RS_ESC  = 2'd2;
  localparam logic [1:0] RS_HELD = 2'd3;

  logic [7:0]    start_r, start_nxt;
  logic [7:0]    end_r, end_nxt;
  logic [7:0]    esc_r, esc_nxt;
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          hold_r, hold_nxt;
  logic          accept;
  logic          full;

  assign in_stall = q_full || hold_r;
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt_r == CW'(FRAME_BYTES));

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    esc_nxt   = esc_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_START: start_nxt = cfg_wdata;
        CFG_END:   end_nxt   = cfg_wdata;
        CFG_ESC:   esc_nxt   = cfg_wdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    logic       store_req;
    logic       fail;
    logic [2:0] fcode;
    logic [1:0] tgt;
    store_req    = 1'b0;
    fail         = 1'b0;
    fcode        = STAT_STORED;
    tgt          = state_r;
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ram_we       = 1'b0;
    ram_waddr    = cnt_r[AW-1:0];
    ram_wdata    = in_rx_byte;
    q_push       = accept;
    q_cmd.dump   = 1'b0;
    q_cmd.status = STAT_STORED;
    if (accept) begin
      if (in_func == FUNC_RELEASE) begin
        state_nxt    = RS_IDLE;
        q_cmd.status = STAT_RELEASED;
      end else begin
        unique case (state_r)
          RS_IDLE: begin
            if (in_rx_byte != start_r) begin
              fail  = 1'b1;
              fcode = STAT_BAD_IDLE;
            end else begin
              // A new frame always starts at the bottom of the store.
              ram_we    = 1'b1;
              ram_waddr = '0;
              cnt_nxt   = CW'(1);
              state_nxt = RS_RECV;
            end
          end
          RS_RECV: begin
            if (in_rx_byte == end_r) begin
              store_req = 1'b1;
              tgt       = RS_HELD;
            end else if (in_rx_byte == esc_r) begin
              store_req = 1'b1;
              tgt       = RS_ESC;
            end else if (in_rx_byte == start_r) begin
              fail  = 1'b1;
              fcode = STAT_START_MID;
            end else begin
              store_req = 1'b1;
              tgt       = RS_RECV;
            end
          end
          RS_ESC: begin
            store_req = 1'b1;
            tgt       = RS_RECV;
          end
          RS_HELD: begin
            fail  = 1'b1;
            fcode = STAT_BYTE_HELD;
          end
        endcase
        if (store_req) begin
          if (full) begin
            fail  = 1'b1;
            fcode = STAT_OVERFLOW;
          end else begin
            ram_we    = 1'b1;
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = tgt;
            if (tgt == RS_HELD) begin
              q_cmd.dump   = 1'b1;
              q_cmd.status = STAT_COMPLETE;
            end
          end
        end
        if (fail) begin
          state_nxt    = RS_IDLE;
          cnt_nxt      = '0;
          q_cmd.status = fcode;
        end
      end
    end
    q_len = cnt_nxt;
  end

  // Input is held off from a completed frame until its dump has drained,
  // so the store is never rewritten while it is being read out.
  always_comb begin
    hold_nxt = hold_r;
    if (q_push && q_cmd.dump) begin
      hold_nxt = 1'b1;
    end else if (dump_done) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 8'd2;
      end_r   <= 8'd3;
      esc_r   <= 8'd16;
      state_r <= RS_IDLE;
      cnt_r   <= '0;
      hold_r  <= 1'b0;
    end else begin
      start_r <= start_nxt;
      end_r   <= end_nxt;
      esc_r   <= esc_nxt;
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

@@ rtl/stxr_back.sv @@
`include "stx_etx_frame_receiver_top_assert.svh"
module stxr_back
  import stxr_pkg::*;
#(
  parameter int AW = 5,
  parameter int CW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  stxr_cmd_t     q_cmd,
  input  logic [CW-1:0] q_len,
  output logic          q_pop,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [7:0]    ram_rdata,
  output logic          dump_done,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    out_status,
  output logic          out_is_frame_byte,
  output logic [7:0]    out_frame_data,
  output logic [4:0]    out_frame_index,
  output logic [5:0]    out_frame_length,
  output logic          out_last
);

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    status_r;
  logic          isb_r;
  logic [7:0]    data_r;
  logic [4:0]    index_r;
  logic [5:0]    length_r;
  logic          last_r;

  logic          dump_r, dump_nxt;
  logic [CW-1:0] len_r;
  logic [CW-1:0] rd_idx_r;
  logic          rd_pend_r, rd_pend_nxt;
  logic [CW-1:0] pend_idx_r;

  logic          load_ok;
  logic          take_pend;
  logic          pend_last;
  logic [CW+5:0] qlen_ext;
  logic [CW+5:0] len_ext;
  logic [CW+4:0] pidx_ext;

  assign load_ok   = !out_valid_r || !out_stall;
  assign take_pend = rd_pend_r && load_ok;
  assign pend_last = (pend_idx_r + CW'(1) == len_r);
  assign ram_re    = dump_r && (rd_idx_r != len_r) && (!rd_pend_r || load_ok);
  assign ram_raddr = rd_idx_r[AW-1:0];
  assign q_pop     = q_valid && !dump_r && (q_cmd.dump || load_ok);
  assign dump_done = take_pend && pend_last;

  assign qlen_ext  = {6'd0, q_len};
  assign len_ext   = {6'd0, len_r};
  assign pidx_ext  = {5'd0, pend_idx_r};

  always_comb begin
    dump_nxt    = dump_r;
    rd_pend_nxt = rd_pend_r;
    if (q_pop && q_cmd.dump) begin
      dump_nxt = 1'b1;
    end else if (dump_done) begin
      dump_nxt = 1'b0;
    end
    if (ram_re) begin
      rd_pend_nxt = 1'b1;
    end else if (take_pend) begin
      rd_pend_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (load_ok) begin
      out_valid_nxt = take_pend || (q_pop && !q_cmd.dump);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      dump_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      dump_r      <= dump_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.dump) begin
      len_r    <= q_len;
      rd_idx_r <= '0;
    end else if (ram_re) begin
      rd_idx_r <= rd_idx_r + CW'(1);
    end
    if (ram_re) begin
      pend_idx_r <= rd_idx_r;
    end
    if (take_pend) begin
      status_r <= STAT_COMPLETE;
      isb_r    <= 1'b1;
      data_r   <= ram_rdata;
      index_r  <= pidx_ext[4:0];
      length_r <= len_ext[5:0];
      last_r   <= pend_last;
    end else if (q_pop && !q_cmd.dump) begin
      status_r <= q_cmd.status;
      isb_r    <= 1'b0;
      data_r   <= 8'd0;
      index_r  <= 5'd0;
      length_r <= qlen_ext[5:0];
      last_r   <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_is_frame_byte = isb_r;
  assign out_frame_data    = data_r;
  assign out_frame_index   = index_r;
  assign out_frame_length  = length_r;
  assign out_last          = last_r;

  `STXR_ASSERT_NOW(a_pend_in_dump, rd_pend_r, dump_r, "read pending outside a dump")
  `STXR_ASSERT_NOW(a_rd_in_bounds, dump_r, rd_idx_r <= len_r, "dump read past frame length")
  `STXR_ASSERT_NOW(a_no_pop_in_dump, dump_r, !q_pop, "queue popped during a dump")
  `STXR_ASSERT_NEXT(a_done_ends_dump, dump_done, !dump_r && !rd_pend_r, "dump did not end")

endmodule

@@ rtl/stx_etx_frame_receiver_top.sv @@
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------------
// in       | in_valid/in_stall  | in_func, in_rx_byte
// out      | out_valid/out_stall| out_status, out_is_frame_byte, out_frame_data,
//          |                    | out_frame_index, out_frame_length, out_last
// cfg      | cfg_we             | cfg_index, cfg_wdata
//
// An input transfer is taken whenever the two-entry command queue has room and no dump
// holds the input. An item that does not end a frame gives a single result, loaded as it
// leaves the queue. A completed frame of N bytes is read from the frame store at one byte
// per cycle while out_stall is low; the input stalls until the last byte is loaded.
// Reset (rst_n, synchronous) restores the delimiter registers and returns to idle; the
// frame store needs no clearing pass, so items are taken right after reset.
module stx_etx_frame_receiver_top
  import stxr_pkg::*;
#(
  parameter int FRAME_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic       out_is_frame_byte,
  output logic [7:0] out_frame_data,
  output logic [4:0] out_frame_index,
  output logic [5:0] out_frame_length,
  output logic       out_last
);

  // Address width of the store, and count width that can also hold a full store.
  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int QW = $bits(stxr_cmd_t) + CW;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          q_push;
  stxr_cmd_t     q_wcmd;
  logic [CW-1:0] q_wlen;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_rdata;
  stxr_cmd_t     q_rcmd;
  logic [CW-1:0] q_rlen;
  logic          dump_done;

  // The front end classifies each byte, tracks the receiver state and writes the store.
  stxr_front #(
    .FRAME_BYTES(FRAME_BYTES),
    .AW         (AW),
    .CW         (CW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_rx_byte(in_rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .q_push    (q_push),
    .q_cmd     (q_wcmd),
    .q_len     (q_wlen),
    .q_full    (q_full),
    .dump_done (dump_done)
  );

  // Commands carry a status or a dump request plus the stored count after the item.
  stxr_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata({q_wcmd, q_wlen}),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .valid(q_valid)
  );

  assign q_rcmd = q_rdata[QW-1:CW];
  assign q_rlen = q_rdata[CW-1:0];

  // Frame store: one write port for the front end, one read port for the dump.
  stxr_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The back end turns commands into results and drives the output register.
  stxr_back #(
    .AW(AW),
    .CW(CW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_rcmd),
    .q_len            (q_rlen),
    .q_pop            (q_pop),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .dump_done        (dump_done),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_is_frame_byte(out_is_frame_byte),
    .out_frame_data   (out_frame_data),
    .out_frame_index  (out_frame_index),
    .out_frame_length (out_frame_length),
    .out_last         (out_last)
  );

endmodule
